/* hw/rtl/dmn_pkg.sv */
// ----------------------------------------------------------------------------
// dmn_pkg: shared types and constants for the distributed mutex node
// Event and message codes, the classified command and the size limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmn_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MARK_W  = 16;

  // peers taking part in the granted check
  localparam int unsigned NODES = 16;
  localparam logic [MARK_W-1:0] NODE_MASK = MARK_W'((33'd1 << NODES) - 33'd1);

  localparam int unsigned DEFER_CAP             = 15;
  localparam int unsigned SAME_TICK_DEFER_LIMIT = 14;
  localparam int unsigned DEFER_SLOTS           = 16;

  localparam int unsigned JOB_DEPTH_DEF = 16;

  // incoming event codes
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_PEER_REQ   = 2'd1;
  localparam logic [1:0] REQ_PEER_GRANT = 2'd2;
  localparam logic [1:0] REQ_ADD_JOB    = 2'd3;

  // outgoing message codes
  localparam logic [KIND_W-1:0] MSG_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] MSG_GRANT   = 2'd1;
  localparam logic [KIND_W-1:0] MSG_ENTRY   = 2'd2;

  // configuration register word index
  localparam logic REG_NODE_NUMBER = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PEER_REQ,
    OP_PEER_GRANT,
    OP_ADD_JOB
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    peer;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/dmn_req_if.sv */
// ----------------------------------------------------------------------------
// dmn_req_if: event channel into the node
// Valid/ready channel carrying one network or job event per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmn_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [dmn_pkg::ID_W-1:0]    peer_id;
  logic [dmn_pkg::STAMP_W-1:0] stamp;

  modport source (output valid, output req_type, output peer_id, output stamp,
                  input ready);
  modport sink   (input valid, input req_type, input peer_id, input stamp,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/dmn_msg_if.sv */
// ----------------------------------------------------------------------------
// dmn_msg_if: message channel out of the node
// Valid/ready channel carrying one outgoing message per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmn_msg_if;
  logic                        valid;
  logic                        ready;
  logic [dmn_pkg::KIND_W-1:0]  msg_kind;
  logic [dmn_pkg::ID_W-1:0]    dest_id;
  logic [dmn_pkg::STAMP_W-1:0] msg_stamp;
  logic [dmn_pkg::STAMP_W-1:0] job_stamp;
  logic                        last;

  modport source (output valid, output msg_kind, output dest_id, output msg_stamp,
                  output job_stamp, output last, input ready);
  modport sink   (input valid, input msg_kind, input dest_id, input msg_stamp,
                  input job_stamp, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dmn_ram.sv */
// ----------------------------------------------------------------------------
// dmn_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dmn_front.sv */
// ----------------------------------------------------------------------------
// dmn_front: event intake and classification
// Decodes each event into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmn_front (
  input  wire logic    clk,
  input  wire logic    rst,
  dmn_req_if.sink      evt,
  output logic         cmd_valid,
  input  wire logic    cmd_ready,
  output dmn_pkg::cmd_t cmd_out
);

  localparam logic [1:0] QDEPTH = 2'd2;

  dmn_pkg::cmd_t slots [2];
  dmn_pkg::cmd_t cmd_new;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  always_comb begin
    cmd_new.peer  = evt.peer_id;
    cmd_new.stamp = evt.stamp;
    case (evt.req_type)
      dmn_pkg::REQ_TICK:       cmd_new.op = dmn_pkg::OP_TICK;
      dmn_pkg::REQ_PEER_REQ:   cmd_new.op = dmn_pkg::OP_PEER_REQ;
      dmn_pkg::REQ_PEER_GRANT: cmd_new.op = dmn_pkg::OP_PEER_GRANT;
      dmn_pkg::REQ_ADD_JOB:    cmd_new.op = dmn_pkg::OP_ADD_JOB;
      default:                 cmd_new.op = dmn_pkg::OP_TICK;
    endcase
  end

  assign evt.ready = (fill != QDEPTH);
  assign cmd_valid = (fill != 2'd0);
  assign cmd_out   = slots[rd_ptr];
  assign push      = evt.valid && evt.ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dmn_back.sv */
// ----------------------------------------------------------------------------
// dmn_back: command execution
// Holds the Lamport clock, grants, deferred peers and job queue; emits
// messages through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmn_back #(
  parameter int unsigned JOB_DEPTH = dmn_pkg::JOB_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [dmn_pkg::ID_W-1:0] node_number,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire dmn_pkg::cmd_t            cmd_in,
  dmn_msg_if.source                     msg
);

  localparam int unsigned AW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = dmn_pkg::STAMP_W;
  localparam int unsigned IW = dmn_pkg::ID_W;
  localparam int unsigned MW = dmn_pkg::MARK_W;
  localparam int unsigned DW = $clog2(dmn_pkg::DEFER_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_ENTER = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t        state, state_next;
  dmn_pkg::cmd_t cmd;
  logic [SW-1:0] lclock, lclock_next;
  logic          pending, pending_next;
  logic [MW-1:0] marks, marks_next;
  logic [IW-1:0] deferred [dmn_pkg::DEFER_SLOTS];
  logic [DW:0]   dcount, dcount_next;
  logic [DW-1:0] fidx, fidx_next;
  logic [AW-1:0] job_head, job_head_next;
  logic [CW-1:0] job_count, job_count_next;

  logic                          out_valid;
  logic [dmn_pkg::KIND_W-1:0]    out_kind;
  logic [IW-1:0]                 out_dest;
  logic [SW-1:0]                 out_mstamp;
  logic [SW-1:0]                 out_jstamp;
  logic                          out_last;

  logic                          out_load;
  logic [dmn_pkg::KIND_W-1:0]    o_kind;
  logic [IW-1:0]                 o_dest;
  logic [SW-1:0]                 o_mstamp;
  logic [SW-1:0]                 o_jstamp;
  logic                          o_last;
  logic                          defer_we;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] head_stamp;

  logic [SW-1:0] clk_inc, clk_inc2, clk_max, req_clk, req_clk2;
  logic          has_job, tick_ready, req_ready, defer, defer_room;
  logic          granted, same_tick_enter, out_free, flush_last, job_room;
  logic [MW-1:0] need_mask;
  logic [AW:0]   push_sum;
  logic [AW-1:0] head_inc;

  dmn_ram #(
    .WIDTH (SW),
    .DEPTH (JOB_DEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.stamp),
    .re    (ram_re),
    .raddr (job_head),
    .rdata (head_stamp)
  );

  assign clk_inc    = lclock + SW'(1);
  assign clk_inc2   = lclock + SW'(2);
  assign clk_max    = (lclock > cmd.stamp) ? lclock : cmd.stamp;
  assign req_clk    = clk_max + SW'(1);
  assign req_clk2   = clk_max + SW'(2);
  assign has_job    = (job_count != '0);
  assign tick_ready = has_job && (clk_inc >= head_stamp);
  assign req_ready  = has_job && (req_clk >= head_stamp);
  assign defer      = req_ready && ((head_stamp < cmd.stamp) ||
                      ((head_stamp == cmd.stamp) && (node_number < cmd.peer)));
  assign defer_room = (dcount < (DW+1)'(dmn_pkg::DEFER_CAP));
  assign need_mask  = dmn_pkg::NODE_MASK & ~(MW'(1) << node_number);
  assign granted    = ((marks & need_mask) == need_mask);
  assign same_tick_enter = granted &&
                           (dcount <= (DW+1)'(dmn_pkg::SAME_TICK_DEFER_LIMIT));
  assign out_free   = !out_valid || msg.ready;
  assign flush_last = (((DW+1)'(fidx) + (DW+1)'(1)) == dcount);
  assign job_room   = (job_count < CW'(JOB_DEPTH));

  // tail slot: head + count stays below twice the depth
  assign push_sum  = (AW+1)'(job_head) + (AW+1)'(job_count);
  assign ram_waddr = (push_sum >= (AW+1)'(JOB_DEPTH)) ?
                     AW'(push_sum - (AW+1)'(JOB_DEPTH)) : AW'(push_sum);
  assign head_inc  = (job_head == AW'(JOB_DEPTH - 1)) ? '0 : job_head + AW'(1);

  assign cmd_ready = (state == ST_IDLE);
  assign ram_re    = (state == ST_IDLE) && cmd_valid;
  assign ram_we    = (state == ST_EXEC) && (cmd.op == dmn_pkg::OP_ADD_JOB) && job_room;

  always_comb begin
    state_next     = state;
    lclock_next    = lclock;
    pending_next   = pending;
    marks_next     = marks;
    dcount_next    = dcount;
    fidx_next      = fidx;
    job_head_next  = job_head;
    job_count_next = job_count;
    out_load       = 1'b0;
    o_kind         = dmn_pkg::MSG_REQUEST;
    o_dest         = '0;
    o_mstamp       = head_stamp;
    o_jstamp       = '0;
    o_last         = 1'b1;
    defer_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd.op)
          dmn_pkg::OP_TICK: begin
            if (pending) begin
              lclock_next = clk_inc;
              state_next  = granted ? ST_ENTER : ST_IDLE;
            end else if (tick_ready) begin
              if (out_free) begin
                out_load     = 1'b1;
                o_kind       = dmn_pkg::MSG_REQUEST;
                o_mstamp     = head_stamp;
                o_last       = !same_tick_enter;
                lclock_next  = clk_inc2;
                pending_next = 1'b1;
                state_next   = same_tick_enter ? ST_ENTER : ST_IDLE;
              end
            end else begin
              lclock_next = clk_inc;
              state_next  = ST_IDLE;
            end
          end
          dmn_pkg::OP_PEER_REQ: begin
            if (defer && defer_room) begin
              defer_we    = 1'b1;
              dcount_next = dcount + (DW+1)'(1);
              lclock_next = req_clk;
              state_next  = ST_IDLE;
            end else if (out_free) begin
              out_load    = 1'b1;
              o_kind      = dmn_pkg::MSG_GRANT;
              o_dest      = cmd.peer;
              o_mstamp    = req_clk2;
              lclock_next = req_clk2;
              state_next  = ST_IDLE;
            end
          end
          dmn_pkg::OP_PEER_GRANT: begin
            marks_next  = marks | (MW'(1) << cmd.peer);
            lclock_next = clk_max;
            state_next  = ST_IDLE;
          end
          dmn_pkg::OP_ADD_JOB: begin
            if (job_room) begin
              job_count_next = job_count + CW'(1);
            end
            state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ENTER: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_kind       = dmn_pkg::MSG_ENTRY;
          o_mstamp     = clk_inc;
          o_jstamp     = has_job ? head_stamp : '0;
          o_last       = (dcount == '0);
          lclock_next  = clk_inc;
          pending_next = 1'b0;
          marks_next   = '0;
          fidx_next    = '0;
          if (has_job) begin
            job_head_next  = head_inc;
            job_count_next = job_count - CW'(1);
          end
          state_next = (dcount == '0) ? ST_IDLE : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_kind      = dmn_pkg::MSG_GRANT;
          o_dest      = deferred[fidx];
          o_mstamp    = clk_inc;
          o_last      = flush_last;
          lclock_next = clk_inc;
          fidx_next   = fidx + DW'(1);
          if (flush_last) begin
            dcount_next = '0;
            state_next  = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lclock    <= '0;
      pending   <= 1'b0;
      marks     <= '0;
      dcount    <= '0;
      fidx      <= '0;
      job_head  <= '0;
      job_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lclock    <= lclock_next;
      pending   <= pending_next;
      marks     <= marks_next;
      dcount    <= dcount_next;
      fidx      <= fidx_next;
      job_head  <= job_head_next;
      job_count <= job_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (msg.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      cmd <= cmd_in;
    end
    if (defer_we) begin
      deferred[dcount[DW-1:0]] <= cmd.peer;
    end
    if (out_load) begin
      out_kind   <= o_kind;
      out_dest   <= o_dest;
      out_mstamp <= o_mstamp;
      out_jstamp <= o_jstamp;
      out_last   <= o_last;
    end
  end

  assign msg.valid     = out_valid;
  assign msg.msg_kind  = out_kind;
  assign msg.dest_id   = out_dest;
  assign msg.msg_stamp = out_mstamp;
  assign msg.job_stamp = out_jstamp;
  assign msg.last      = out_last;

endmodule

`default_nettype wire

/* hw/rtl/distributed_mutex_node_top.sv */
// ----------------------------------------------------------------------------
// distributed_mutex_node_top: one Ricart-Agrawala mutual exclusion node
// Lamport-clocked request/grant protocol with a local job queue.
// ----------------------------------------------------------------------------
// Usage:
//   evt  - one event per beat: tick, peer request, peer go-ahead or job add.
//   msg  - outgoing messages: request broadcast, go-ahead to a peer, or
//          critical-section entry; last marks the final beat of an event.
//   APB  - node_number at byte address 0; write it only while the node is
//          idle. pready is tied high, reads return the register.
// Timing:
//   An event is queued in a two-entry command queue and executed by the
//   back end one at a time; the job-queue head is read through the RAM's
//   registered read port before the event executes. An entry with deferred
//   peers is followed by one go-ahead per deferred peer, one per cycle
//   while msg.ready holds, paced by the single output register.
//   The event side keeps accepting while a message waits in the output
//   register, until the command queue fills.
// Reset: clears the clock, grants, pending request and both queue counts;
//   job and deferred-peer storage is left as is; an unwritten word is never used.
// Stall: a held msg.ready freezes the back end at its next message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distributed_mutex_node_top #(
  parameter int unsigned JOB_DEPTH = dmn_pkg::JOB_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  dmn_req_if.sink          evt,
  dmn_msg_if.source        msg,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [dmn_pkg::ID_W-1:0] node_number;
  logic                     cfg_sel;
  logic                     cmd_valid;
  logic                     cmd_ready;
  dmn_pkg::cmd_t            cmd;

  // word index 0 holds node_number; other addresses read as zero
  assign cfg_sel = (paddr[2] == dmn_pkg::REG_NODE_NUMBER);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(32-dmn_pkg::ID_W){1'b0}}, node_number} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_number <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      node_number <= pwdata[dmn_pkg::ID_W-1:0];
    end
  end

  // front end: accept and classify events
  dmn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_out   (cmd)
  );

  // back end: protocol state and message generation
  dmn_back #(
    .JOB_DEPTH (JOB_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .node_number (node_number),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_in      (cmd),
    .msg         (msg)
  );

endmodule

`default_nettype wire
